/* rtl/cddm_pkg.sv */
package cddm_pkg;

  localparam int VALUE_W    = 16;
  localparam int BIT_W      = 4;   // counts the VALUE_W conversion passes
  localparam int BCD_DIGITS = 5;   // enough decimal digits for any VALUE_W number
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int EN_W       = 4;
  localparam int DIGITS_DEF = 4;
  localparam int HOLD_W     = 8;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd2;
  localparam logic [EN_W-1:0]   ALL_OFF    = 4'hF;

  typedef enum logic [1:0] {
    ACT_RESET   = 2'd0,
    ACT_CLOCK   = 2'd1,
    ACT_ENABLES = 2'd2,
    ACT_HOLD    = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_CONV  = 4'd1,
    ST_SEL   = 4'd2,
    ST_RESET = 4'd3,
    ST_CLK   = 4'd4,
    ST_EN    = 4'd5,
    ST_HOLD  = 4'd6,
    ST_OFF   = 4'd7,
    ST_BLANK = 4'd8
  } step_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_CONV,
    OP_SEL,
    OP_DEC,
    OP_NEXT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_INPUT,
    C_BIT_MORE,
    C_BLANK,
    C_CNT_NZ,
    C_DIG_MORE
  } cond_t;

  typedef enum logic [1:0] {
    EN_ZERO,
    EN_OFF,
    EN_DIGIT
  } en_sel_t;

  // one microcode word
  typedef struct packed {
    op_t     op;
    logic    emit;
    logic    emit_on_hit;  // beat only when the jump is taken
    act_t    action;
    en_sel_t en_sel;
    logic    last_chk;
    cond_t   cond;
    step_t   hit;
    step_t   miss;
  } cw_t;

  // sequencer -> datapath
  typedef struct packed {
    op_t     op;
    logic    emit;
    act_t    action;
    en_sel_t en_sel;
    logic    last_chk;
  } ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic in_valid;
    logic bit_more;
    logic blank;
    logic cnt_nz;
    logic dig_more;
    logic stall;
  } stat_t;

  function automatic cw_t ucode(step_t s);
    cw_t w;
    w = '{op: OP_NONE, emit: 1'b0, emit_on_hit: 1'b0, action: ACT_RESET,
          en_sel: EN_ZERO, last_chk: 1'b0, cond: C_NEVER, hit: ST_IDLE,
          miss: ST_IDLE};
    case (s)
      ST_IDLE: begin
        w.op = OP_LOAD; w.cond = C_INPUT; w.hit = ST_CONV; w.miss = ST_IDLE;
      end
      ST_CONV: begin
        w.op = OP_CONV; w.cond = C_BIT_MORE; w.hit = ST_CONV; w.miss = ST_SEL;
      end
      ST_SEL: begin
        w.op = OP_SEL; w.cond = C_BLANK; w.hit = ST_BLANK; w.miss = ST_RESET;
      end
      ST_RESET: begin
        w.emit = 1'b1; w.action = ACT_RESET; w.miss = ST_CLK;
      end
      ST_CLK: begin
        w.op = OP_DEC; w.emit = 1'b1; w.emit_on_hit = 1'b1; w.action = ACT_CLOCK;
        w.cond = C_CNT_NZ; w.hit = ST_CLK; w.miss = ST_EN;
      end
      ST_EN: begin
        w.emit = 1'b1; w.action = ACT_ENABLES; w.en_sel = EN_DIGIT; w.miss = ST_HOLD;
      end
      ST_HOLD: begin
        w.emit = 1'b1; w.action = ACT_HOLD; w.miss = ST_OFF;
      end
      ST_OFF: begin
        w.op = OP_NEXT; w.emit = 1'b1; w.action = ACT_ENABLES; w.en_sel = EN_OFF;
        w.last_chk = 1'b1; w.cond = C_DIG_MORE; w.hit = ST_SEL; w.miss = ST_IDLE;
      end
      ST_BLANK: begin
        w.emit = 1'b1; w.action = ACT_ENABLES; w.en_sel = EN_OFF; w.miss = ST_HOLD;
      end
      default: begin
        w.miss = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/cddm_seq.sv */
module cddm_seq
  import cddm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctl_t  ctl
);

  step_t upc;
  step_t upc_next;
  cw_t   cw;
  logic  hit;

  always_comb begin
    cw = ucode(upc);
    case (cw.cond)
      C_NEVER:    hit = 1'b0;
      C_INPUT:    hit = stat.in_valid;
      C_BIT_MORE: hit = stat.bit_more;
      C_BLANK:    hit = stat.blank;
      C_CNT_NZ:   hit = stat.cnt_nz;
      C_DIG_MORE: hit = stat.dig_more;
      default:    hit = 1'b0;
    endcase
    ctl.op       = cw.op;
    ctl.emit     = cw.emit && (!cw.emit_on_hit || hit);
    ctl.action   = cw.action;
    ctl.en_sel   = cw.en_sel;
    ctl.last_chk = cw.last_chk;
    if (stat.stall) begin
      upc_next = upc;
    end else if (hit) begin
      upc_next = cw.hit;
    end else begin
      upc_next = cw.miss;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

/* rtl/cddm_datapath.sv */
module cddm_datapath
  import cddm_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_t               ctl,
  output stat_t              stat,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         action,
  output logic [EN_W-1:0]    enables,
  output logic               last
);

  localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGITS - 1);

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   adj;
  logic [BIT_W-1:0]   bitcnt;
  logic [IDX_W-1:0]   idx;
  logic               lead;
  logic [3:0]         cnt;
  logic [EN_W-1:0]    en_pat;
  logic [3:0]         digit;
  logic [EN_W-1:0]    digit_pat;
  logic               lead_next;
  logic               stall;
  act_t               out_act;
  logic [EN_W-1:0]    out_en;
  logic               out_last;
  logic [EN_W-1:0]    beat_en;

  // add-3 correction on every BCD digit before the shift
  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (bcd[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd[4*k +: 4];
      end
    end
  end

  // digit idx counts from the most significant shown position
  always_comb begin
    digit = 4'd0;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (k == DIGITS - 1 - int'(idx)) begin
        digit = bcd[4*k +: 4];
      end
    end
    for (int b = 0; b < EN_W; b++) begin
      digit_pat[b] = (int'(idx) != b);
    end
    lead_next = lead && (digit == 4'd0);
  end

  assign in_ready = (ctl.op == OP_LOAD);
  assign stall    = ctl.emit && out_valid && !out_ready;

  always_comb begin
    stat.in_valid = in_valid;
    stat.bit_more = (bitcnt != BIT_W'(VALUE_W - 1));
    stat.blank    = lead_next && (idx != LAST_IDX);
    stat.cnt_nz   = (cnt != 4'd0);
    stat.dig_more = (idx != LAST_IDX);
    stat.stall    = stall;
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      case (ctl.op)
        OP_LOAD: begin
          if (in_valid) begin
            bin    <= value;
            bcd    <= '0;
            bitcnt <= '0;
            idx    <= '0;
            lead   <= 1'b1;
          end
        end
        OP_CONV: begin
          bcd    <= {adj[BCD_W-2:0], bin[VALUE_W-1]};
          bin    <= {bin[VALUE_W-2:0], 1'b0};
          bitcnt <= bitcnt + 1'b1;
        end
        OP_SEL: begin
          lead   <= lead_next;
          cnt    <= digit;
          en_pat <= digit_pat;
        end
        OP_DEC: begin
          if (cnt != 4'd0) begin
            cnt <= cnt - 1'b1;
          end
        end
        OP_NEXT: begin
          if (idx != LAST_IDX) begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ctl.en_sel)
      EN_ZERO:  beat_en = '0;
      EN_OFF:   beat_en = ALL_OFF;
      EN_DIGIT: beat_en = en_pat;
      default:  beat_en = '0;
    endcase
  end

  // output register: the next beat loads as soon as the current one leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit && !stall) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && !stall) begin
      out_act  <= ctl.action;
      out_en   <= beat_en;
      out_last <= ctl.last_chk && (idx == LAST_IDX);
    end
  end

  assign action  = out_act;
  assign enables = out_en;
  assign last    = out_last;

endmodule

/* rtl/counter_driven_digit_multiplexer_unit.sv */
// Channel  Handshake             Payload
// cfg      cfg_valid/cfg_ready   hold_ms[7:0]
// in       in_valid/in_ready     value[15:0]
// out      out_valid/out_ready   action[1:0], enables[3:0], last
//
// Steps per number: accept, 16 binary-to-BCD passes, then per digit select,
// blank, hold, off for a blanked leading zero, or select, reset, d clock beats,
// enables, hold, off for a shown digit d. The sequencer issues one step per cycle.
// Reset (rst, sync, high) returns the sequencer to idle, empties the output
// register and sets hold_time to 2.
// A stalled out beat freezes the sequencer; in_ready is high only while idle.
module counter_driven_digit_multiplexer_unit
  import cddm_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [HOLD_W-1:0]  hold_ms,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         action,
  output logic [EN_W-1:0]    enables,
  output logic               last
);

  ctl_t              ctl;
  stat_t             stat;
  // hold time register; it drives no output and shapes no beat here
  logic [HOLD_W-1:0] hold_time;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time <= HOLD_RESET;
    end else if (cfg_valid) begin
      hold_time <= hold_ms;
    end
  end

  // sequencer: step counter plus microcode table, two-way jumps
  cddm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // datapath: double-dabble converter, digit select, clock count, out beat
  cddm_datapath #(
    .DIGITS (DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action),
    .enables   (enables),
    .last      (last)
  );

endmodule

/* rtl/cddm_checker.sv */
module cddm_checker
  import cddm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         action,
  input logic [EN_W-1:0]    enables,
  input logic               last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(enables)
      && $stable(last))
    else $error("out beat changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after a number was taken");

  a_last_is_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> action == ACT_ENABLES && enables == ALL_OFF)
    else $error("last beat is not all enables off");

  a_en_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != ACT_ENABLES |-> enables == '0)
    else $error("enables nonzero outside set enables");

endmodule

bind counter_driven_digit_multiplexer_unit cddm_checker u_cddm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .action    (action),
  .enables   (enables),
  .last      (last)
);
